// File: rtl/core/lce_pkg.sv
// Shared types and constants of the linear convolution engine.
package lce_pkg;

	// Fixed widths of the command and result fields.
	localparam int OP_W   = 2;
	localparam int SLOT_W = 5;
	localparam int VAL_W  = 16;
	localparam int LEN_W  = 6;
	localparam int POS_W  = 6;
	localparam int OUT_W  = 37;

	// Configuration port.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// Length register values after reset.
	localparam logic [LEN_W-1:0] SIGNAL_LENGTH_RESET = LEN_W'(24);
	localparam logic [LEN_W-1:0] KERNEL_LENGTH_RESET = LEN_W'(11);

	// Register indexes, taken from the word address bit.
	localparam logic REG_SIGNAL_LENGTH = 1'b0;
	localparam logic REG_KERNEL_LENGTH = 1'b1;

	// Command opcodes.
	typedef enum logic [OP_W-1:0] {
		OP_SIGNAL_WRITE = 2'd0,
		OP_KERNEL_WRITE = 2'd1,
		OP_RUN          = 2'd2
	} op_t;

	// Sequencer states.
	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	// Control that travels with one product term down the pipeline.
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             sum_last;
		logic             run_last;
		logic [POS_W-1:0] pos;
	} term_t;

endpackage

// File: rtl/core/lce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/lce_seq.sv
// Run sequencer: walks every (position, term) pair and issues store reads.
module lce_seq import lce_pkg::*; #(
	parameter int MAX_SIGNAL = 32,
	parameter int MAX_KERNEL = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [LEN_W-1:0]              signal_length,
	input  logic [LEN_W-1:0]              kernel_length,
	input  logic                          en,
	output logic [$clog2(MAX_SIGNAL)-1:0] sig_addr,
	output logic [$clog2(MAX_KERNEL)-1:0] ker_addr,
	output logic                          busy,
	output term_t                         term_s1
);

	localparam int SAW = $clog2(MAX_SIGNAL);
	localparam int KAW = $clog2(MAX_KERNEL);

	seq_state_t       state_q, state_d;
	logic [LEN_W-1:0] m_q, n_q;
	logic [POS_W-1:0] last_pos_q;
	logic [POS_W-1:0] i_q, j_q;
	logic             first_q;
	logic [POS_W-1:0] k_c, m_minus1, jhi, i_nx, jlo_nx;
	logic             sum_end, run_end;
	logic [LEN_W-1:0] m_cl, n_cl;
	term_t            term_c;

	// A length of zero counts as one, a length above the store depth as the depth.
	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
		input logic [LEN_W-1:0] depth);
		logic [LEN_W-1:0] r;
		if (len == '0) begin
			r = LEN_W'(1);
		end else if (len > depth) begin
			r = depth;
		end else begin
			r = len;
		end
		return r;
	endfunction

	assign m_cl = clamp_len(signal_length, LEN_W'(MAX_SIGNAL));
	assign n_cl = clamp_len(kernel_length, LEN_W'(MAX_KERNEL));

	// Window of the current position and the start of the next one.
	assign k_c      = i_q - j_q;
	assign m_minus1 = m_q - LEN_W'(1);
	assign jhi      = (i_q < m_minus1) ? i_q : m_minus1;
	assign sum_end  = (j_q == jhi);
	assign run_end  = sum_end && (i_q == last_pos_q);
	assign i_nx     = i_q + POS_W'(1);
	assign jlo_nx   = (i_nx >= n_q) ? (i_nx - n_q + POS_W'(1)) : '0;

	assign sig_addr = j_q[SAW-1:0];
	assign ker_addr = k_c[KAW-1:0];
	assign busy     = (state_q == SEQ_RUN);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and the term issued this cycle.
	always_comb begin
		state_d         = state_q;
		term_c          = '0;
		term_c.first    = first_q;
		term_c.sum_last = sum_end;
		term_c.run_last = run_end;
		term_c.pos      = i_q;
		case (state_q)
			SEQ_IDLE: begin
				if (start) begin
					state_d = SEQ_RUN;
				end
			end
			SEQ_RUN: begin
				term_c.valid = 1'b1;
				if (en && run_end) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// Position and term counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			j_q        <= '0;
			first_q    <= 1'b0;
			m_q        <= LEN_W'(1);
			n_q        <= LEN_W'(1);
			last_pos_q <= '0;
		end else if (state_q == SEQ_IDLE) begin
			if (start) begin
				m_q        <= m_cl;
				n_q        <= n_cl;
				last_pos_q <= POS_W'(m_cl + n_cl - LEN_W'(2));
				i_q        <= '0;
				j_q        <= '0;
				first_q    <= 1'b1;
			end
		end else if (en) begin
			if (sum_end) begin
				i_q     <= i_nx;
				j_q     <= jlo_nx;
				first_q <= 1'b1;
			end else begin
				j_q     <= j_q + POS_W'(1);
				first_q <= 1'b0;
			end
		end
	end

	// Term control, aligned with the registered store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_s1 <= '0;
		end else if (en) begin
			term_s1 <= term_c;
		end
	end

	// Addresses stay inside both stores' valid windows during a run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_RUN) |-> ((j_q < m_q) && (j_q <= i_q) && (k_c < n_q)))
		else $error("term index outside the valid window");

	// The final term of a run returns the sequencer to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == SEQ_RUN) && en && run_end) |=> (state_q == SEQ_IDLE))
		else $error("sequencer did not stop after the final term");

	// A valid term in the read stage was issued by a running sequencer.
	assert property (@(posedge clk) disable iff (!arst_n)
		($rose(term_s1.valid)) |-> ($past(state_q) == SEQ_RUN))
		else $error("term issued outside a run");

endmodule

// File: rtl/core/lce_mac.sv
// Shared multiply-accumulate unit with the result register.
module lce_mac import lce_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  term_t                          term_s1,
	input  logic [SAMPLE_WIDTH-1:0]        sig_rdata,
	input  logic [SAMPLE_WIDTH-1:0]        ker_rdata,
	output logic                           busy,
	output logic                           res_valid,
	output logic [POS_W-1:0]               out_position,
	output logic signed [OUT_W-1:0]        out_value,
	output logic                           out_last
);

	localparam int PW = 2 * SAMPLE_WIDTH;
	localparam int XW = (PW > OUT_W) ? PW : OUT_W;

	logic signed [PW-1:0]    prod_s2;
	term_t                   term_s2;
	logic signed [XW-1:0]    prod_x;
	logic signed [OUT_W-1:0] prod_ext, acc_q, sum_c;

	// Multiply stage.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= $signed(sig_rdata) * $signed(ker_rdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_s2 <= '0;
		end else if (en) begin
			term_s2 <= term_s1;
		end
	end

	// Sign-extend the product to the sum width, wrapping if it is wider.
	assign prod_x   = XW'(prod_s2);
	assign prod_ext = prod_x[OUT_W-1:0];
	assign sum_c    = (term_s2.first ? '0 : acc_q) + prod_ext;
	assign busy     = term_s2.valid;

	// Accumulate and capture each finished sum.
	always_ff @(posedge clk) begin
		if (en && term_s2.valid) begin
			acc_q <= sum_c;
			if (term_s2.sum_last) begin
				out_value    <= sum_c;
				out_position <= term_s2.pos;
				out_last     <= term_s2.run_last;
			end
		end
	end

	// Result beat flag; en is low only while a beat waits under stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= term_s2.valid && term_s2.sum_last;
		end
	end

endmodule

// File: rtl/core/linear_convolution_engine_top.sv
// Top level of the linear convolution engine: stores, sequencer, MAC and registers.
//
//  Channel   Handshake               Beat contents
//  command   cmd_valid / cmd_stall   opcode, slot, sample_value
//  result    res_valid / res_stall   out_position, out_value, out_last
//  config    APB psel/penable/...    signal_length (0x0), kernel_length (0x4)
//
// A load command writes its store entry when it is accepted. A run issues m*n product
// terms, one at a time, to the shared MAC through the read, multiply and accumulate
// stages, where m and n are the clamped signal and kernel lengths.
// Reset sets the lengths to 24 and 11; the stores are not cleared.
// A stalled result beat freezes the sequencer, the store reads and the MAC.
// Commands are held off from the start of a run until its last term is summed.
module linear_convolution_engine_top import lce_pkg::*; #(
	parameter int MAX_SIGNAL   = 32,
	parameter int MAX_KERNEL   = 32,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_stall,
	input  logic [OP_W-1:0]         opcode,
	input  logic [SLOT_W-1:0]       slot,
	input  logic signed [VAL_W-1:0] sample_value,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [POS_W-1:0]        out_position,
	output logic signed [OUT_W-1:0] out_value,
	output logic                    out_last,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready
);

	localparam int SAW = $clog2(MAX_SIGNAL);
	localparam int KAW = $clog2(MAX_KERNEL);
	localparam int EW  = (SAMPLE_WIDTH > VAL_W) ? SAMPLE_WIDTH : VAL_W;

	logic [LEN_W-1:0]        signal_length_q, kernel_length_q;
	logic                    cmd_accept, cfg_write, en;
	logic                    sig_wr_en, ker_wr_en, run_start;
	logic [EW-1:0]           value_ext;
	logic [SAMPLE_WIDTH-1:0] wr_data;
	logic [SAW-1:0]          sig_addr;
	logic [KAW-1:0]          ker_addr;
	logic [SAMPLE_WIDTH-1:0] sig_rdata, ker_rdata;
	logic                    seq_busy, mac_busy;
	term_t                   term_s1;

	// Configuration registers on the APB port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signal_length_q <= SIGNAL_LENGTH_RESET;
			kernel_length_q <= KERNEL_LENGTH_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_SIGNAL_LENGTH: signal_length_q <= pwdata[LEN_W-1:0];
				REG_KERNEL_LENGTH: kernel_length_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SIGNAL_LENGTH: prdata = DATA_W'(signal_length_q);
			REG_KERNEL_LENGTH: prdata = DATA_W'(kernel_length_q);
			default:           prdata = '0;
		endcase
	end

	// Command decode.
	assign cmd_stall  = seq_busy || term_s1.valid || mac_busy;
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign value_ext  = EW'($unsigned(sample_value));
	assign wr_data    = value_ext[SAMPLE_WIDTH-1:0];

	always_comb begin
		sig_wr_en = 1'b0;
		ker_wr_en = 1'b0;
		run_start = 1'b0;
		case (op_t'(opcode))
			OP_SIGNAL_WRITE: sig_wr_en = cmd_accept && (LEN_W'(slot) < LEN_W'(MAX_SIGNAL));
			OP_KERNEL_WRITE: ker_wr_en = cmd_accept && (LEN_W'(slot) < LEN_W'(MAX_KERNEL));
			OP_RUN:          run_start = cmd_accept;
			default: ;
		endcase
	end

	// The whole run pipeline advances unless a result beat is held.
	assign en = !(res_valid && res_stall);

	lce_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_SIGNAL)) u_signal_store (
		.clk     (clk),
		.wr_en   (sig_wr_en),
		.wr_addr (slot[SAW-1:0]),
		.wr_data (wr_data),
		.rd_en   (en),
		.rd_addr (sig_addr),
		.rd_data (sig_rdata)
	);

	lce_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_KERNEL)) u_kernel_store (
		.clk     (clk),
		.wr_en   (ker_wr_en),
		.wr_addr (slot[KAW-1:0]),
		.wr_data (wr_data),
		.rd_en   (en),
		.rd_addr (ker_addr),
		.rd_data (ker_rdata)
	);

	lce_seq #(.MAX_SIGNAL(MAX_SIGNAL), .MAX_KERNEL(MAX_KERNEL)) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (run_start),
		.signal_length (signal_length_q),
		.kernel_length (kernel_length_q),
		.en            (en),
		.sig_addr      (sig_addr),
		.ker_addr      (ker_addr),
		.busy          (seq_busy),
		.term_s1       (term_s1)
	);

	lce_mac #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.term_s1      (term_s1),
		.sig_rdata    (sig_rdata),
		.ker_rdata    (ker_rdata),
		.busy         (mac_busy),
		.res_valid    (res_valid),
		.out_position (out_position),
		.out_value    (out_value),
		.out_last     (out_last)
	);

endmodule

// File: verif/linear_convolution_engine_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the linear convolution engine: loads, runs and length registers.
module linear_convolution_engine_top_tb;
	import lce_pkg::*;

	localparam int DEPTH         = 32;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 2000000;

	// Opcode that the engine does not decode.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam logic [ADDR_W-1:0] ADDR_SIGNAL_LENGTH = {REG_SIGNAL_LENGTH, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_KERNEL_LENGTH = {REG_KERNEL_LENGTH, 2'b00};

	typedef struct packed {
		logic [OP_W-1:0]         opcode;
		logic [SLOT_W-1:0]       slot;
		logic signed [VAL_W-1:0] value;
	} cmd_beat_t;

	typedef struct packed {
		logic [POS_W-1:0]        pos;
		logic signed [OUT_W-1:0] value;
		logic                    last;
	} conv_result_t;

	typedef enum {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    cmd_valid    = 1'b0;
	logic                    cmd_stall;
	logic [OP_W-1:0]         opcode       = '0;
	logic [SLOT_W-1:0]       slot         = '0;
	logic signed [VAL_W-1:0] sample_value = '0;
	logic                    res_valid;
	logic                    res_stall    = 1'b0;
	logic [POS_W-1:0]        out_position;
	logic signed [OUT_W-1:0] out_value;
	logic                    out_last;
	logic                    psel         = 1'b0;
	logic                    penable      = 1'b0;
	logic                    pwrite       = 1'b0;
	logic [ADDR_W-1:0]       paddr        = '0;
	logic [DATA_W-1:0]       pwdata       = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;

	// Predicted engine state: the two stores and the length registers.
	logic signed [VAL_W-1:0] signal_mem [DEPTH];
	logic signed [VAL_W-1:0] kernel_mem [DEPTH];
	logic [LEN_W-1:0]        signal_len_reg = SIGNAL_LENGTH_RESET;
	logic [LEN_W-1:0]        kernel_len_reg = KERNEL_LENGTH_RESET;

	// Entries that the queued commands have loaded so far.
	bit signal_loaded [DEPTH];
	bit kernel_loaded [DEPTH];

	conv_result_t conv_expect [$];
	cmd_beat_t    cmd_q [$];
	cmd_beat_t    cmd_cur;

	int cycle_count     = 0;
	int mismatches      = 0;
	int results_checked = 0;
	int beats_sent      = 0;
	int runs_sent       = 0;
	int settings_used   = 0;
	int burst_left      = 0;
	int gap_left        = 0;
	int hold_left       = 0;
	int mode_left       = 0;
	bit hold_done       = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;

	linear_convolution_engine_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.opcode       (opcode),
		.slot         (slot),
		.sample_value (sample_value),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.out_position (out_position),
		.out_value    (out_value),
		.out_last     (out_last),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #1 clk = ~clk;

	// A length of zero acts as one, and a length past the store depth as the depth.
	function automatic int clamp_length(logic [LEN_W-1:0] len);
		if (len == 0)
			return 1;
		if (len > DEPTH)
			return DEPTH;
		return int'(len);
	endfunction

	function automatic void flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
	endfunction

	// Update the stores for a load, or queue every output of the convolution for a run.
	function automatic void apply_command(cmd_beat_t c);
		int m;
		int n;
		int total;
		int lo;
		int hi;
		longint acc;
		conv_result_t r;
		case (c.opcode)
			OP_SIGNAL_WRITE: signal_mem[c.slot] = c.value;
			OP_KERNEL_WRITE: kernel_mem[c.slot] = c.value;
			OP_RUN: begin
				runs_sent++;
				m = clamp_length(signal_len_reg);
				n = clamp_length(kernel_len_reg);
				total = m + n - 1;
				for (int i = 0; i < total; i++) begin
					acc = 0;
					lo = (i + 1 > n) ? i + 1 - n : 0;
					hi = (i < m - 1) ? i : m - 1;
					for (int j = lo; j <= hi; j++)
						acc += longint'(signal_mem[j]) * longint'(kernel_mem[i - j]);
					r.pos = POS_W'(i);
					r.value = acc[OUT_W-1:0];
					r.last = (i == total - 1);
					conv_expect.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	// Command driver: bursts of beats with random gaps, payload held while stalled.
	always @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			apply_command(cmd_cur);
			beats_sent++;
		end
		if (!cmd_valid || !cmd_stall) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				cmd_cur = cmd_q.pop_front();
				cmd_valid <= 1'b1;
				opcode <= cmd_cur.opcode;
				slot <= cmd_cur.slot;
				sample_value <= cmd_cur.value;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Result receiver: a stall pattern that is picked anew at random, plus one long hold.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (!hold_done && results_checked >= 40 && res_valid) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			res_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				STALL_NONE:  res_stall <= 1'b0;
				STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 6);
				default:     res_stall <= (cycle_count % 3 == 0);
			endcase
		end
	end

	// Result monitor: each accepted beat against the oldest expected output.
	always @(posedge clk) begin
		conv_result_t want;
		if (res_valid && !res_stall) begin
			if (conv_expect.size() == 0) begin
				flag_mismatch($sformatf("unexpected result pos %0d value %0d last %0b",
					out_position, out_value, out_last));
			end else begin
				want = conv_expect.pop_front();
				results_checked++;
				if (out_position !== want.pos || out_value !== want.value ||
						out_last !== want.last)
					flag_mismatch($sformatf(
						"expected pos %0d value %0d last %0b, got pos %0d value %0d last %0b",
						want.pos, want.value, want.last, out_position, out_value, out_last));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_SIGNAL_LENGTH)
			signal_len_reg = data[LEN_W-1:0];
		else
			kernel_len_reg = data[LEN_W-1:0];
	endtask

	task automatic check_reg(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] want);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== DATA_W'(want))
			flag_mismatch($sformatf("register at %0d: expected %0d, read %0d",
				addr, want, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write both lengths with junk in the unused data bits, then read them back.
	task automatic set_lengths(logic [LEN_W-1:0] sig_len, logic [LEN_W-1:0] ker_len);
		logic [DATA_W-1:0] data;
		data = $urandom;
		data[LEN_W-1:0] = sig_len;
		write_reg(ADDR_SIGNAL_LENGTH, data);
		data = $urandom;
		data[LEN_W-1:0] = ker_len;
		write_reg(ADDR_KERNEL_LENGTH, data);
		check_reg(ADDR_SIGNAL_LENGTH, sig_len);
		check_reg(ADDR_KERNEL_LENGTH, ker_len);
		settings_used++;
	endtask

	// Wait for all beats to go out and all outputs to come back, then let loads settle.
	// The falling edge is used so that the rising-edge updates of driver and monitor have landed.
	task automatic wait_idle();
		while (cmd_q.size() != 0 || cmd_valid || conv_expect.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic void queue_cmd(logic [OP_W-1:0] op, int s, logic [VAL_W-1:0] v);
		cmd_beat_t c;
		c.opcode = op;
		c.slot = SLOT_W'(s);
		c.value = v;
		if (op == OP_SIGNAL_WRITE)
			signal_loaded[s] = 1'b1;
		if (op == OP_KERNEL_WRITE)
			kernel_loaded[s] = 1'b1;
		cmd_q.push_back(c);
	endfunction

	// A run never reads an entry that was not loaded since reset, so fill the gaps first.
	function automatic void queue_run();
		int m;
		int n;
		m = clamp_length(signal_len_reg);
		n = clamp_length(kernel_len_reg);
		for (int j = 0; j < m; j++)
			if (!signal_loaded[j])
				queue_cmd(OP_SIGNAL_WRITE, j, pick_value());
		for (int j = 0; j < n; j++)
			if (!kernel_loaded[j])
				queue_cmd(OP_KERNEL_WRITE, j, pick_value());
		queue_cmd(OP_RUN, $urandom_range(0, DEPTH - 1), pick_value());
	endfunction

	// One length setting: loads mostly inside the active range, some runs, some noise.
	task automatic random_phase(logic [LEN_W-1:0] sig_len, logic [LEN_W-1:0] ker_len,
			int count);
		int m;
		int n;
		int pick;
		int s;
		set_lengths(sig_len, ker_len);
		m = clamp_length(sig_len);
		n = clamp_length(ker_len);
		repeat (count) begin
			pick = $urandom_range(0, 19);
			if (pick < 3) begin
				queue_run();
			end else if (pick == 3) begin
				queue_cmd(OP_UNUSED, $urandom_range(0, DEPTH - 1), pick_value());
			end else begin
				if ($urandom_range(0, 3) != 0)
					s = $urandom_range(0, ((pick < 12) ? m : n) - 1);
				else
					s = $urandom_range(0, DEPTH - 1);
				queue_cmd((pick < 12) ? OP_SIGNAL_WRITE : OP_KERNEL_WRITE, s, pick_value());
			end
		end
		queue_run();
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lengths come out of reset at their documented values.
		check_reg(ADDR_SIGNAL_LENGTH, SIGNAL_LENGTH_RESET);
		check_reg(ADDR_KERNEL_LENGTH, KERNEL_LENGTH_RESET);

		// Directed: full-scale samples of both signs, the ignored opcode, the top slot.
		set_lengths(6'd3, 6'd2);
		queue_cmd(OP_SIGNAL_WRITE, 0, 16'h7FFF);
		queue_cmd(OP_SIGNAL_WRITE, 1, 16'h8000);
		queue_cmd(OP_SIGNAL_WRITE, 2, 16'hFFFF);
		queue_cmd(OP_KERNEL_WRITE, 0, 16'h8000);
		queue_cmd(OP_KERNEL_WRITE, 1, 16'h7FFF);
		queue_cmd(OP_RUN, 0, 16'h0000);
		queue_cmd(OP_UNUSED, 0, 16'h1234);
		queue_cmd(OP_UNUSED, 31, 16'h7FFF);
		queue_cmd(OP_SIGNAL_WRITE, 31, 16'h8000);
		queue_cmd(OP_KERNEL_WRITE, 31, 16'h7FFF);
		queue_cmd(OP_RUN, 31, 16'hFFFF);
		queue_cmd(OP_SIGNAL_WRITE, 0, 16'h8000);
		queue_cmd(OP_SIGNAL_WRITE, 1, 16'h8000);
		queue_cmd(OP_SIGNAL_WRITE, 2, 16'h8000);
		queue_cmd(OP_KERNEL_WRITE, 0, 16'h8000);
		queue_cmd(OP_KERNEL_WRITE, 1, 16'h8000);
		queue_cmd(OP_RUN, 5, 16'h5555);
		queue_cmd(OP_SIGNAL_WRITE, 0, 16'h0000);
		queue_cmd(OP_KERNEL_WRITE, 0, 16'h0001);
		queue_cmd(OP_RUN, 10, 16'hAAAA);
		wait_idle();

		// Random phases over the length extremes, the reset values, small settings and one random setting.
		random_phase(6'd1, 6'd1, 14);
		random_phase(6'd32, 6'd32, 14);
		random_phase(6'd0, 6'd63, 14);
		random_phase(6'd63, 6'd0, 14);
		random_phase(SIGNAL_LENGTH_RESET, KERNEL_LENGTH_RESET, 14);
		repeat (4)
			random_phase(LEN_W'($urandom_range(1, 8)), LEN_W'($urandom_range(1, 8)), 14);
		random_phase(LEN_W'($urandom_range(0, 63)), LEN_W'($urandom_range(0, 63)), 14);

		$display("tb: sent %0d command beats with %0d runs over %0d length settings",
			beats_sent, runs_sent, settings_used);
		$display("tb: checked %0d convolution outputs, %0d mismatches",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
